/* design/ttw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttw_pkg
// Shared types and codes of the text terminal writer: command classes that
// the front end hands to the back end, control bytes and register indexes.
// ----------------------------------------------------------------------------
package ttw_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_SETCUR = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN = 8'd13;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE = 8'd32;

  localparam logic [7:0] RESET_ATTR = 8'h07;

  localparam logic REG_FOREGROUND = 1'b0;
  localparam logic REG_BACKGROUND = 1'b1;

  localparam logic [2:0] K_PUT = 3'd0;
  localparam logic [2:0] K_NEWLINE = 3'd1;
  localparam logic [2:0] K_RETURN = 3'd2;
  localparam logic [2:0] K_TAB = 3'd3;
  localparam logic [2:0] K_BACKSPACE = 3'd4;
  localparam logic [2:0] K_SETCUR = 3'd5;
  localparam logic [2:0] K_CLEAR = 3'd6;
  localparam logic [2:0] K_READ = 3'd7;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] ch;
    logic [7:0] col;
    logic [7:0] row;
  } cmd_t;

endpackage
`default_nettype wire

/* design/ttw_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttw_front
// Accepts input transfers, classifies each into a command and holds up to
// two commands for the back end.
// ----------------------------------------------------------------------------
module ttw_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_op,
  input  wire logic [7:0]         in_char_code,
  input  wire logic [7:0]         in_column_arg,
  input  wire logic [7:0]         in_row_arg,
  output logic                    q_valid,
  output ttw_pkg::cmd_t           q_cmd,
  input  wire logic               q_take
);
  import ttw_pkg::*;

  cmd_t       entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  cmd_t       cmd_in;
  logic       push, pop;

  always_comb begin
    cmd_in.ch = in_char_code;
    cmd_in.col = in_column_arg;
    cmd_in.row = in_row_arg;
    unique case (in_op)
      OP_WRITE: begin
        case (in_char_code)
          CH_NEWLINE: cmd_in.kind = K_NEWLINE;
          CH_RETURN: cmd_in.kind = K_RETURN;
          CH_TAB: cmd_in.kind = K_TAB;
          CH_BACKSPACE: cmd_in.kind = K_BACKSPACE;
          default: cmd_in.kind = K_PUT;
        endcase
      end
      OP_SETCUR: cmd_in.kind = K_SETCUR;
      OP_CLEAR: cmd_in.kind = K_CLEAR;
      default: cmd_in.kind = K_READ;
    endcase
  end

  assign in_stall = (count_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (count_r != 2'd0);
  assign q_cmd = entry_r[rd_ptr_r];
  assign pop = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

/* design/ttw_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttw_back
// Carries out commands on the screen store and the cursor, sweeps the store
// for scrolling and clearing, and holds the result register.
// ----------------------------------------------------------------------------
module ttw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25,
  parameter int TAB_SPACES = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [7:0]         attr,
  input  wire logic               q_valid,
  input  wire ttw_pkg::cmd_t      q_cmd,
  output logic                    q_take,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [15:0]             out_cell_value,
  output logic [4:0]              out_cursor_row,
  output logic [6:0]              out_cursor_column,
  output logic                    out_scrolled
);
  import ttw_pkg::*;

  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW = $clog2(DEPTH);
  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLUMNS);
  localparam int TW = $clog2(TAB_SPACES + 1);
  localparam logic [AW-1:0] COLS_A = AW'(COLUMNS);
  localparam logic [AW-1:0] LAST_MOVE = AW'((ROWS - 1) * COLUMNS - 1);
  localparam logic [AW-1:0] LAST_CELL = AW'(DEPTH - 1);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_TAB = 3'd3;
  localparam logic [2:0] S_SCR_RD = 3'd4;
  localparam logic [2:0] S_SCR_WR = 3'd5;
  localparam logic [2:0] S_FILL = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [15:0]   mem [DEPTH];
  logic [15:0]   rd_r;
  logic          we;
  logic [AW-1:0] wa, ra;
  logic [15:0]   wd;

  logic [2:0]    state_r, state_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [TW-1:0] tab_r, tab_nxt;
  logic          sc_r, sc_nxt;
  logic          rd_ok_r, rd_ok_nxt;
  logic [15:0]   cell_r, cell_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [15:0]   out_cell_r, out_cell_nxt;
  logic [4:0]    out_row_r, out_row_nxt;
  logic [6:0]    out_col_r, out_col_nxt;
  logic          out_sc_r, out_sc_nxt;

  logic [AW-1:0] cur_addr;
  logic          col_last, row_last;
  logic [7:0]    row_wide, col_wide;

  assign cur_addr = AW'(row_r) * COLS_A + AW'(col_r);
  assign col_last = (col_r == CW'(COLUMNS - 1));
  assign row_last = (row_r == RW'(ROWS - 1));
  assign row_wide = 8'(row_r);
  assign col_wide = 8'(col_r);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_r <= mem[ra];
  end

  always_comb begin
    state_nxt = state_r;
    row_nxt = row_r;
    col_nxt = col_r;
    ptr_nxt = ptr_r;
    tab_nxt = tab_r;
    sc_nxt = sc_r;
    rd_ok_nxt = rd_ok_r;
    cell_nxt = cell_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_cell_nxt = out_cell_r;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    out_sc_nxt = out_sc_r;
    q_take = 1'b0;
    we = 1'b0;
    wa = cur_addr;
    wd = {attr, CH_SPACE};
    ra = ptr_r + COLS_A;

    unique case (state_r)
      S_INIT: begin
        we = 1'b1;
        wa = ptr_r;
        wd = {RESET_ATTR, CH_SPACE};
        ptr_nxt = ptr_r + AW'(1);
        if (ptr_r == LAST_CELL) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid) begin
          q_take = 1'b1;
          sc_nxt = 1'b0;
          cell_nxt = 16'd0;
          state_nxt = S_DONE;
          case (q_cmd.kind)
            K_PUT: begin
              we = 1'b1;
              wd = {attr, q_cmd.ch};
              col_nxt = col_r + CW'(1);
              if (col_last) begin
                col_nxt = '0;
                if (row_last) begin
                  sc_nxt = 1'b1;
                  ptr_nxt = '0;
                  state_nxt = S_SCR_RD;
                end else begin
                  row_nxt = row_r + RW'(1);
                end
              end
            end
            K_NEWLINE: begin
              col_nxt = '0;
              if (row_last) begin
                sc_nxt = 1'b1;
                ptr_nxt = '0;
                state_nxt = S_SCR_RD;
              end else begin
                row_nxt = row_r + RW'(1);
              end
            end
            K_RETURN: col_nxt = '0;
            K_TAB: begin
              tab_nxt = TW'(TAB_SPACES);
              state_nxt = S_TAB;
            end
            K_BACKSPACE: begin
              // The cell before the cursor is always cur_addr - 1, also
              // when the cursor steps back into the previous row.
              wa = cur_addr - AW'(1);
              if (col_r != '0) begin
                we = 1'b1;
                col_nxt = col_r - CW'(1);
              end else if (row_r != '0) begin
                we = 1'b1;
                row_nxt = row_r - RW'(1);
                col_nxt = CW'(COLUMNS - 1);
              end
            end
            K_SETCUR: begin
              col_nxt = (q_cmd.col >= 8'(COLUMNS)) ? CW'(COLUMNS - 1) : q_cmd.col[CW-1:0];
              row_nxt = (q_cmd.row >= 8'(ROWS)) ? RW'(ROWS - 1) : q_cmd.row[RW-1:0];
            end
            K_CLEAR: begin
              row_nxt = '0;
              col_nxt = '0;
              ptr_nxt = '0;
              state_nxt = S_FILL;
            end
            default: begin
              rd_ok_nxt = (q_cmd.col < 8'(COLUMNS)) && (q_cmd.row < 8'(ROWS));
              ra = AW'(q_cmd.row[RW-1:0]) * COLS_A + AW'(q_cmd.col[CW-1:0]);
              state_nxt = S_READ;
            end
          endcase
        end
      end
      S_READ: begin
        cell_nxt = rd_ok_r ? rd_r : 16'd0;
        state_nxt = S_DONE;
      end
      S_TAB: begin
        we = 1'b1;
        tab_nxt = tab_r - TW'(1);
        col_nxt = col_r + CW'(1);
        state_nxt = (tab_r == TW'(1)) ? S_DONE : S_TAB;
        if (col_last) begin
          col_nxt = '0;
          if (row_last) begin
            sc_nxt = 1'b1;
            ptr_nxt = '0;
            state_nxt = S_SCR_RD;
          end else begin
            row_nxt = row_r + RW'(1);
          end
        end
      end
      S_SCR_RD: begin
        state_nxt = S_SCR_WR;
      end
      S_SCR_WR: begin
        we = 1'b1;
        wa = ptr_r;
        wd = rd_r;
        ptr_nxt = ptr_r + AW'(1);
        state_nxt = (ptr_r == LAST_MOVE) ? S_FILL : S_SCR_RD;
      end
      S_FILL: begin
        we = 1'b1;
        wa = ptr_r;
        ptr_nxt = ptr_r + AW'(1);
        if (ptr_r == LAST_CELL) begin
          state_nxt = (tab_r != '0) ? S_TAB : S_DONE;
        end
      end
      default: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_cell_nxt = cell_r;
          out_row_nxt = row_wide[4:0];
          out_col_nxt = col_wide[6:0];
          out_sc_nxt = sc_r;
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      ptr_r <= '0;
      row_r <= '0;
      col_r <= '0;
      tab_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r <= ptr_nxt;
      row_r <= row_nxt;
      col_r <= col_nxt;
      tab_r <= tab_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sc_r <= sc_nxt;
    rd_ok_r <= rd_ok_nxt;
    cell_r <= cell_nxt;
    out_cell_r <= out_cell_nxt;
    out_row_r <= out_row_nxt;
    out_col_r <= out_col_nxt;
    out_sc_r <= out_sc_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_cell_value = out_cell_r;
  assign out_cursor_row = out_row_r;
  assign out_cursor_column = out_col_r;
  assign out_scrolled = out_sc_r;

endmodule
`default_nettype wire

/* design/text_terminal_writer_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_terminal_writer_unit
// Character-cell text terminal with a ROWS x COLUMNS screen store and cursor.
// ----------------------------------------------------------------------------
// After reset the unit fills the screen store with blank cells; up to two
// items are queued meanwhile and carried out once the fill is done.
// Register writes are taken at any time.
// A two-entry command queue sits in front of
// the execution engine, so items are taken while one is being carried out.
// The engine handles one item at a time through a single-port-write screen
// store: set cursor, return, newline, backspace and printable characters go
// straight from idle to the result, a read passes through a read state, a tab
// writes TAB_SPACES blank cells, and a clear blanks every cell. A scroll reads
// and rewrites each cell of rows 1..ROWS-1 one row up, then blanks the last row.
module text_terminal_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25,
  parameter int TAB_SPACES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_op,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [7:0]  in_column_arg,
  input  wire logic [7:0]  in_row_arg,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_cell_value,
  output logic [4:0]       out_cursor_row,
  output logic [6:0]       out_cursor_column,
  output logic             out_scrolled,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [3:0]  cfg_data
);
  import ttw_pkg::*;

  logic [3:0] fg_r, bg_r;
  logic       q_valid, q_take;
  cmd_t       q_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= 4'd7;
      bg_r <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FOREGROUND: fg_r <= cfg_data;
        default: bg_r <= cfg_data;
      endcase
    end
  end

  ttw_front u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_op(in_op),
    .in_char_code(in_char_code),
    .in_column_arg(in_column_arg),
    .in_row_arg(in_row_arg),
    .q_valid(q_valid),
    .q_cmd(q_cmd),
    .q_take(q_take)
  );

  ttw_back #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS),
    .TAB_SPACES(TAB_SPACES)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .attr({bg_r, fg_r}),
    .q_valid(q_valid),
    .q_cmd(q_cmd),
    .q_take(q_take),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_cell_value(out_cell_value),
    .out_cursor_row(out_cursor_row),
    .out_cursor_column(out_cursor_column),
    .out_scrolled(out_scrolled)
  );

  // A result never reports a cursor column beyond the last column.
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (8'(out_cursor_column) < 8'(COLUMNS)))
    else $error("cursor column out of range");

  // Reset empties the queue and the result register.
  a_reset_stall: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire
